### hdl/class_chi_squared_scorer_defines.svh
`ifndef CLASS_CHI_SQUARED_SCORER_DEFINES_SVH
`define CLASS_CHI_SQUARED_SCORER_DEFINES_SVH

// check in the next cycle, outside reset
`define CCS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

// check in the same cycle, outside reset
`define CCS_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// check in the next cycle, reset included
`define CCS_ASSERT_ALWAYS(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

`endif

### hdl/ccs_pkg.sv
`timescale 1ns / 1ps
package ccs_pkg;
  localparam int NUM_LABELS = 16;
  localparam int MAX_ROWS   = 65536;
  localparam int LBL_W      = $clog2(NUM_LABELS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int CNT_W      = 17;
  localparam int STAT_W     = 32;
  localparam int PRD_W      = 2 * CNT_W + 1;
  localparam int MUL_W      = 36;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int DEN_W      = 68;
  localparam int REM_W      = DEN_W;
  localparam int NUMH_W     = 70;

  localparam logic [1:0] MODE_LOAD_LABEL = 2'd0;
  localparam logic [1:0] MODE_LOAD_TOTAL = 2'd1;
  localparam logic [1:0] MODE_ADD_ROW    = 2'd2;
  localparam logic [1:0] MODE_FINISH     = 2'd3;

  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [STAT_W-1:0] Q_ONE    = 32'h8000_0000;
  localparam logic [LBL_W-1:0]  LAST_LBL = LBL_W'(NUM_LABELS - 1);
endpackage

### hdl/ccs_ram.sv
`timescale 1ns / 1ps
module ccs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hdl/ccs_mul.sv
`timescale 1ns / 1ps
module ccs_mul (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ccs_pkg::MUL_W-1:0] a,
  input  logic [ccs_pkg::MUL_W-1:0] b,
  output logic                      done,
  output logic [ccs_pkg::PROD_W-1:0] prod
);
  import ccs_pkg::*;
  localparam int HALF = MUL_W / 2;

  logic [MUL_W-1:0]  xa, xb;
  logic [1:0]        step;
  logic              busy;
  logic [HALF-1:0]   xs, ys;
  logic [MUL_W-1:0]  pp;
  logic [PROD_W-1:0] sh;

  assign xs = step[1] ? xa[MUL_W-1:HALF] : xa[HALF-1:0];
  assign ys = step[0] ? xb[MUL_W-1:HALF] : xb[HALF-1:0];
  assign pp = xs * ys;

  always_comb begin
    case (step) inside
      2'd0:       sh = PROD_W'(pp);
      2'd1, 2'd2: sh = PROD_W'(pp) << HALF;
      default:    sh = PROD_W'(pp) << MUL_W;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        xa   <= a;
        xb   <= b;
        prod <= '0;
        step <= 2'd0;
        busy <= 1'b1;
      end else if (busy) begin
        prod <= prod + sh;
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### hdl/ccs_div.sv
`timescale 1ns / 1ps
module ccs_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ccs_pkg::NUMH_W-1:0] num_hi,
  input  logic [ccs_pkg::STAT_W-1:0] num_lo,
  input  logic [ccs_pkg::DEN_W-1:0]  den,
  output logic                       done,
  output logic [ccs_pkg::STAT_W-1:0] quo
);
  import ccs_pkg::*;

  logic [REM_W-1:0]  rem;
  logic [STAT_W-1:0] lo, q;
  logic [5:0]        cnt;
  logic              busy, sat;
  logic [REM_W:0]    t, sub;
  logic              ge;

  assign t   = {rem, lo[STAT_W-1]};
  assign sub = t - {1'b0, den};
  assign ge  = t >= {1'b0, den};
  assign quo = (sat || q > Q_ONE) ? Q_ONE : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= num_hi[REM_W-1:0];
        lo   <= num_lo;
        sat  <= num_hi >= NUMH_W'(den);
        q    <= '0;
        cnt  <= 6'(STAT_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? sub[REM_W-1:0] : t[REM_W-1:0];
        q   <= {q[STAT_W-2:0], ge};
        lo  <= lo << 1;
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### hdl/class_chi_squared_scorer.sv
`timescale 1ns / 1ps
// channel  | direction | handshake            | payload
// in       | to block  | in_valid / in_stall  | mode, row_index, label, class_count, bound_mode
// out      | from block| out_valid / out_stall| statistic, rows_counted
// cfg      | to block  | cfg_wr_en            | cfg_wr_data (total_rows)
// Label load: a label RAM write. Class total load: count RAM read, then write-back. Add row: label
// RAM, then count RAM read-modify-write. Finish: per label, up to two terms of four products each on
// the shared multiplier and one divide; the upper bound repeats the pass for each of 16 labels.
// Reset is synchronous; row labels are undefined until loaded, totals and counts read as zero.
// A finished result waits in the output register while new items are taken.
module class_chi_squared_scorer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [ccs_pkg::CNT_W-1:0]  cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 mode,
  input  logic [ccs_pkg::ROW_W-1:0]  row_index,
  input  logic [ccs_pkg::LBL_W-1:0]  label,
  input  logic [ccs_pkg::CNT_W-1:0]  class_count,
  input  logic                       bound_mode,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ccs_pkg::STAT_W-1:0] statistic,
  output logic [ccs_pkg::CNT_W-1:0]  rows_counted
);
  import ccs_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_TOT_WB  = 15'b000000000000010,
    S_ADD_LBL = 15'b000000000000100,
    S_ADD_WB  = 15'b000000000001000,
    S_NSQ     = 15'b000000000010000,
    S_KRD     = 15'b000000000100000,
    S_ARD     = 15'b000000001000000,
    S_JRD     = 15'b000000010000000,
    S_JDAT    = 15'b000000100000000,
    S_MSTART  = 15'b000001000000000,
    S_MUL     = 15'b000010000000000,
    S_DSTART  = 15'b000100000000000,
    S_DIV     = 15'b001000000000000,
    S_PASS    = 15'b010000000000000,
    S_OUT     = 15'b100000000000000
  } state_t;

  state_t state;

  logic [CNT_W-1:0]      total_rows, set_size;
  logic [NUM_LABELS-1:0] tot_valid, cnt_valid;
  logic                  bound, side;
  logic [LBL_W-1:0]      k, j, rd_idx;
  logic [1:0]            mstep;
  logic [CNT_W-1:0]      a_r, b_r, g_r, c_r, hold_cnt;
  logic [MUL_W-1:0]      nsq;
  logic [PRD_W-1:0]      p1, p2;
  logic [NUMH_W:0]       p3;
  logic [DEN_W-1:0]      den_r;
  logic [STAT_W-1:0]     acc, best;

  logic                  in_acc;
  logic                  lbl_we;
  logic [LBL_W-1:0]      lbl_rdata;
  logic                  cnt_we;
  logic [LBL_W-1:0]      cnt_raddr;
  logic [2*CNT_W-1:0]    cnt_wdata, cnt_rdata;
  logic [CNT_W-1:0]      tot_eff, cnt_eff, cnt_inc, a_sel, g_sel, c_sel, s_sel, abs_cc;
  logic                  neg;
  logic signed [PRD_W+1:0] diff;
  logic [MUL_W-1:0]      mag;
  logic                  mul_start, mul_done, div_done;
  logic [MUL_W-1:0]      mul_a, mul_b;
  logic [PROD_W-1:0]     prod;
  logic [STAT_W-1:0]     quo;
  logic [STAT_W:0]       acc_sum;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign lbl_we   = in_acc && (mode == MODE_LOAD_LABEL);

  ccs_ram #(.WIDTH(LBL_W), .DEPTH(MAX_ROWS)) u_lbl_ram (
    .clk   (clk),
    .we    (lbl_we),
    .waddr (row_index),
    .wdata (label),
    .raddr (row_index),
    .rdata (lbl_rdata)
  );

  always_comb begin
    unique case (state)
      S_IDLE:    cnt_raddr = label;
      S_ADD_LBL: cnt_raddr = lbl_rdata;
      S_KRD:     cnt_raddr = k;
      default:   cnt_raddr = j;
    endcase
  end

  assign tot_eff = tot_valid[rd_idx] ? cnt_rdata[2*CNT_W-1:CNT_W] : '0;
  assign cnt_eff = cnt_valid[rd_idx] ? cnt_rdata[CNT_W-1:0] : '0;
  assign cnt_inc = (cnt_eff == CNT_MAX) ? cnt_eff : cnt_eff + 1'b1;
  assign cnt_we  = (state == S_TOT_WB) || (state == S_ADD_WB);
  assign cnt_wdata = (state == S_TOT_WB) ? {hold_cnt, cnt_rdata[CNT_W-1:0]}
                                         : {cnt_rdata[2*CNT_W-1:CNT_W], cnt_inc};

  ccs_ram #(.WIDTH(2*CNT_W), .DEPTH(NUM_LABELS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (rd_idx),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  assign a_sel  = bound ? cnt_eff : set_size;
  assign g_sel  = tot_eff;
  assign c_sel  = (!bound || j == k) ? cnt_eff : '0;
  assign s_sel  = side ? b_r : a_r;
  assign neg    = side && (c_r > g_r);
  assign abs_cc = !side ? c_r : (neg ? c_r - g_r : g_r - c_r);
  assign diff   = (neg ? -$signed({2'b0, p1}) : $signed({2'b0, p1})) - $signed({2'b0, p2});
  assign mag    = diff[PRD_W+1] ? MUL_W'(-diff) : MUL_W'(diff);

  always_comb begin
    if (state == S_IDLE) begin
      mul_a = MUL_W'(total_rows);
      mul_b = MUL_W'(total_rows);
    end else begin
      case (mstep)
        2'd0: begin
          mul_a = MUL_W'(total_rows);
          mul_b = MUL_W'(abs_cc);
        end
        2'd1: begin
          mul_a = MUL_W'(s_sel);
          mul_b = MUL_W'(g_r);
        end
        2'd2: begin
          mul_a = mag;
          mul_b = mag;
        end
        default: begin
          mul_a = nsq;
          mul_b = MUL_W'(p2);
        end
      endcase
    end
  end

  assign mul_start = (state == S_MSTART) || (in_acc && mode == MODE_FINISH);

  ccs_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  ccs_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (state == S_DSTART),
    .num_hi (p3[NUMH_W:1]),
    .num_lo ({p3[0], {(STAT_W-1){1'b0}}}),
    .den    (den_r),
    .done   (div_done),
    .quo    (quo)
  );

  assign acc_sum = {1'b0, acc} + {1'b0, quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      total_rows <= CNT_W'(1);
      set_size   <= '0;
      tot_valid  <= '0;
      cnt_valid  <= '0;
      out_valid  <= 1'b0;
    end else begin
      rd_idx <= cnt_raddr;
      if (cfg_wr_en) begin
        total_rows <= cfg_wr_data;
      end
      if (state == S_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            unique case (mode)
              MODE_LOAD_TOTAL: begin
                hold_cnt <= class_count;
                state    <= S_TOT_WB;
              end
              MODE_ADD_ROW: begin
                if (set_size != CNT_MAX) set_size <= set_size + 1'b1;
                state <= S_ADD_LBL;
              end
              MODE_FINISH: begin
                bound <= bound_mode;
                k     <= '0;
                best  <= '0;
                state <= S_NSQ;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_TOT_WB: begin
          tot_valid[rd_idx] <= 1'b1;
          state <= S_IDLE;
        end
        S_ADD_LBL: state <= S_ADD_WB;
        S_ADD_WB: begin
          cnt_valid[rd_idx] <= 1'b1;
          state <= S_IDLE;
        end
        S_NSQ: begin
          if (mul_done) begin
            nsq   <= prod[MUL_W-1:0];
            state <= S_KRD;
          end
        end
        S_KRD: state <= S_ARD;
        S_ARD: begin
          if (total_rows == '0) begin
            a_r <= '0;
            b_r <= '0;
          end else begin
            a_r <= a_sel;
            b_r <= (total_rows > a_sel) ? total_rows - a_sel : '0;
          end
          acc   <= '0;
          j     <= '0;
          state <= S_JRD;
        end
        S_JRD: state <= S_JDAT;
        S_JDAT: begin
          g_r   <= g_sel;
          c_r   <= c_sel;
          mstep <= 2'd0;
          if (g_sel != '0 && a_r != '0) begin
            side  <= 1'b0;
            state <= S_MSTART;
          end else if (g_sel != '0 && b_r != '0) begin
            side  <= 1'b1;
            state <= S_MSTART;
          end else if (j == LAST_LBL) begin
            state <= S_PASS;
          end else begin
            j     <= j + 1'b1;
            state <= S_JRD;
          end
        end
        S_MSTART: state <= S_MUL;
        S_MUL: begin
          if (mul_done) begin
            mstep <= mstep + 2'd1;
            state <= S_MSTART;
            case (mstep)
              2'd0: p1 <= prod[PRD_W-1:0];
              2'd1: p2 <= prod[PRD_W-1:0];
              2'd2: p3 <= prod[NUMH_W:0];
              default: begin
                den_r <= prod[DEN_W-1:0];
                state <= S_DSTART;
              end
            endcase
          end
        end
        S_DSTART: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            acc <= (acc_sum > {1'b0, Q_ONE}) ? Q_ONE : acc_sum[STAT_W-1:0];
            mstep <= 2'd0;
            if (!side && b_r != '0) begin
              side  <= 1'b1;
              state <= S_MSTART;
            end else if (j == LAST_LBL) begin
              state <= S_PASS;
            end else begin
              j     <= j + 1'b1;
              state <= S_JRD;
            end
          end
        end
        S_PASS: begin
          if (acc > best) best <= acc;
          if (bound && k != LAST_LBL) begin
            k     <= k + 1'b1;
            state <= S_KRD;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            statistic    <= best;
            rows_counted <= set_size;
            set_size     <= '0;
            cnt_valid    <= '0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### hdl/ccs_checker.sv
`timescale 1ns / 1ps
`include "class_chi_squared_scorer_defines.svh"
module ccs_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [ccs_pkg::STAT_W-1:0] statistic,
  input logic [ccs_pkg::CNT_W-1:0]  rows_counted
);
  import ccs_pkg::*;

  `CCS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(statistic) && $stable(rows_counted), "stalled result changed")
  `CCS_ASSERT_NOW(a_stat_range, out_valid, statistic <= Q_ONE, "statistic above one")
  `CCS_ASSERT_NOW(a_result_after_work, $rose(out_valid), $past(in_stall), "result without finish work")
  `CCS_ASSERT_ALWAYS(a_reset_clear, rst, !out_valid && !in_stall, "not idle after reset")
endmodule

bind class_chi_squared_scorer ccs_checker u_ccs_checker (.*);
